/* design/encoder_period_tachometer_unit_macros.svh */
// Assertion macros shared by the tachometer modules.
`ifndef ENCODER_PERIOD_TACHOMETER_UNIT_MACROS_SVH
`define ENCODER_PERIOD_TACHOMETER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define EPT_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tachometer assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define EPT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tachometer assertion failed");

`endif

/* design/ept_pkg.sv */
`timescale 1ns / 1ps

package ept_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_CAPTURE = 2'd1;
    localparam logic [1:0] OP_FETCH   = 2'd2;

    // Field and state widths.
    localparam int CAP_W    = 16;
    localparam int PERIOD_W = 21;
    localparam int SUM_W    = 24;
    localparam int ACC_W    = 22;
    localparam int CNT32_W  = 32;
    localparam int LIMIT_W  = 20;

    // Timer span and the constants derived from it.
    localparam int TIMER_SPAN = 65536;
    localparam logic [CAP_W:0] SPAN_EXT = (CAP_W + 1)'(TIMER_SPAN);
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(TIMER_SPAN - 1);
    localparam logic signed [ACC_W-1:0] SPAN_ACC = ACC_W'(TIMER_SPAN);

    localparam logic [SUM_W-1:0] SUM_MAX = 24'hFFFFFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd1000000;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam logic REG_SAT_LIMIT = 1'b0;

    // Class of a word after decoding.
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_EDGE  = 2'd1,
        KIND_FETCH = 2'd2
    } ept_kind_t;

    // Command word passed from the front to the back.
    typedef struct packed {
        ept_kind_t        kind;
        logic             ch;
        logic [CAP_W-1:0] cap;
        logic             dist_mode;
        logic             fwd;
    } ept_cmd_t;

endpackage

/* design/ept_front.sv */
`timescale 1ns / 1ps

module ept_front import ept_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_op,
    input  logic             s_channel,
    input  logic [CAP_W-1:0] s_capture_time,
    input  logic             s_distance_mode,
    input  logic             s_forward,
    output logic             push_valid,
    output ept_cmd_t         push_cmd,
    input  logic             push_ready
);

    logic     f_valid_reg;
    ept_cmd_t f_cmd_reg;
    ept_cmd_t cmd_next;
    logic     keep;

    // Decode the operation; the unused code is dropped here.
    always_comb begin
        cmd_next.ch        = s_channel;
        cmd_next.dist_mode = s_distance_mode;
        cmd_next.fwd       = s_forward;
        // Capture times beyond the timer span clamp to its top value.
        cmd_next.cap = ({1'b0, s_capture_time} >= SPAN_EXT) ? CAP_MAX : s_capture_time;
        keep          = 1'b1;
        cmd_next.kind = KIND_TICK;
        unique case (s_op)
            OP_TICK:    cmd_next.kind = KIND_TICK;
            OP_CAPTURE: cmd_next.kind = KIND_EDGE;
            OP_FETCH:   cmd_next.kind = KIND_FETCH;
            default:    keep = 1'b0;
        endcase
    end

    // The holding register frees whenever its word moves into the queue.
    assign s_ready    = !f_valid_reg || push_ready;
    assign push_valid = f_valid_reg;
    assign push_cmd   = f_cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (s_ready) begin
            f_valid_reg <= s_valid && keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            f_cmd_reg <= cmd_next;
        end
    end

endmodule

/* design/ept_queue.sv */
`timescale 1ns / 1ps
`include "encoder_period_tachometer_unit_macros.svh"

module ept_queue import ept_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    input  ept_cmd_t push_cmd,
    output logic     push_ready,
    output logic     pop_valid,
    output ept_cmd_t pop_cmd,
    input  logic     pop_ready
);

    ept_cmd_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    // Storage of queued words.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `EPT_ASSERT_IMPLY(a_count_bound, aclk, aresetn, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `EPT_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + QCNT_W'(1))

endmodule

/* design/ept_back.sv */
`timescale 1ns / 1ps
`include "encoder_period_tachometer_unit_macros.svh"

module ept_back import ept_pkg::*; #(
    parameter int AVG_COUNT = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [LIMIT_W-1:0]         limit,
    input  logic                       pop_valid,
    input  ept_cmd_t                   pop_cmd,
    output logic                       pop_ready,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_out_channel,
    output logic [PERIOD_W-1:0]        m_period,
    output logic [PERIOD_W-1:0]        m_average_period,
    output logic                       m_average_updated,
    output logic [CNT32_W-1:0]         m_distance_count,
    output logic signed [CNT32_W-1:0]  m_turn_count,
    output logic signed [CNT32_W-1:0]  m_other_turn_count
);

    // Division by the group size as a multiply by a rounded-up reciprocal.
    localparam int CNT_W     = $clog2(AVG_COUNT + 1);
    localparam int DIV_L     = $clog2(AVG_COUNT);
    localparam int DIV_SHIFT = SUM_W + DIV_L;
    localparam int MUL_W     = SUM_W + 1;
    localparam int PROD_W    = SUM_W + MUL_W;
    localparam logic [63:0] MUL_FULL = ((64'd1 << DIV_SHIFT) / 64'(AVG_COUNT)) + 64'd1;
    localparam logic [MUL_W-1:0] DIV_MUL = MUL_FULL[MUL_W-1:0];

    // Per-wheel state.
    logic signed [ACC_W-1:0] accum_reg [2];
    logic [SUM_W-1:0]        sum_reg   [2];
    logic [CNT_W-1:0]        cnt_reg   [2];
    logic [PERIOD_W-1:0]     avg_reg   [2];
    logic [CNT32_W-1:0]      dist_reg  [2];
    logic [CNT32_W-1:0]      turn_reg  [2];

    // Execute stage register.
    logic                s1_valid_reg;
    logic                s1_ch_reg;
    logic                s1_fetch_reg;
    logic [PERIOD_W-1:0] s1_period_reg;
    logic                s1_done_reg;
    logic [SUM_W-1:0]    s1_sum_reg;
    logic [CNT32_W-1:0]  s1_dist_reg;
    logic [CNT32_W-1:0]  s1_turn_reg;
    logic [CNT32_W-1:0]  s1_other_reg;

    // Output register.
    logic                m_valid_reg;
    logic                m_ch_reg;
    logic [PERIOD_W-1:0] m_period_reg;
    logic [PERIOD_W-1:0] m_avg_reg;
    logic                m_upd_reg;
    logic [CNT32_W-1:0]  m_dist_reg;
    logic [CNT32_W-1:0]  m_turn_reg;
    logic [CNT32_W-1:0]  m_other_reg;

    logic                    out_free;
    logic                    s1_adv;
    logic                    s1_free;
    logic                    pop;
    logic                    ch;
    logic signed [ACC_W-1:0] cap_s;
    logic signed [ACC_W-1:0] limit_s;
    logic signed [ACC_W-1:0] p_sum;
    logic [PERIOD_W-1:0]     period;
    logic [SUM_W:0]          sum_wide;
    logic [SUM_W-1:0]        sum_sat;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    done;
    logic [CNT32_W-1:0]      dist_inc;
    logic [CNT32_W-1:0]      turn_step;
    logic signed [ACC_W-1:0] tick_acc  [2];
    logic signed [ACC_W-1:0] tick_next [2];
    logic [PROD_W-1:0]       prod;
    logic [PERIOD_W-1:0]     avg_new;
    logic [PERIOD_W-1:0]     avg_out;

    // Stage handshakes: each stage moves when the one after it can take a word.
    assign out_free  = !m_valid_reg || m_ready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign s1_free   = !s1_valid_reg || out_free;
    assign pop_ready = s1_free;
    assign pop       = pop_valid && s1_free;

    // Period, sum, group count, distance and turn arithmetic for the addressed wheel; overflow ticks for both.
    always_comb begin
        ch        = pop_cmd.ch;
        cap_s     = $signed({{(ACC_W - CAP_W){1'b0}}, pop_cmd.cap});
        limit_s   = $signed({{(ACC_W - LIMIT_W){1'b0}}, limit});
        p_sum     = accum_reg[ch] + cap_s;
        period    = p_sum[ACC_W-1] ? '0 : p_sum[PERIOD_W-1:0];
        sum_wide  = {1'b0, sum_reg[ch]} + {{(SUM_W + 1 - PERIOD_W){1'b0}}, period};
        sum_sat   = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
        cnt_inc   = cnt_reg[ch] + CNT_W'(1);
        done      = (cnt_inc >= CNT_W'(AVG_COUNT));
        dist_inc  = dist_reg[ch] + CNT32_W'(1);
        turn_step = pop_cmd.fwd ? (turn_reg[ch] + CNT32_W'(1)) : (turn_reg[ch] - CNT32_W'(1));
        for (int i = 0; i < 2; i++) begin
            tick_acc[i]  = accum_reg[i] + SPAN_ACC;
            tick_next[i] = (tick_acc[i] >= limit_s) ? limit_s : tick_acc[i];
        end
    end

    // State update as each word leaves the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                accum_reg[i] <= '0;
                sum_reg[i]   <= '0;
                cnt_reg[i]   <= '0;
                dist_reg[i]  <= '0;
                turn_reg[i]  <= '0;
            end
        end else if (pop) begin
            unique case (pop_cmd.kind)
                KIND_TICK: begin
                    for (int i = 0; i < 2; i++) begin
                        accum_reg[i] <= tick_next[i];
                    end
                end
                KIND_EDGE: begin
                    accum_reg[ch] <= -cap_s;
                    sum_reg[ch]   <= done ? '0 : sum_sat;
                    cnt_reg[ch]   <= done ? '0 : cnt_inc;
                    if (pop_cmd.dist_mode) begin
                        dist_reg[ch] <= dist_inc;
                    end else begin
                        turn_reg[ch] <= turn_step;
                    end
                end
                KIND_FETCH: begin
                    turn_reg[0] <= '0;
                    turn_reg[1] <= '0;
                end
                default: ;
            endcase
        end
    end

    // Execute stage valid; ticks leave no result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_free) begin
            s1_valid_reg <= pop && (pop_cmd.kind == KIND_EDGE || pop_cmd.kind == KIND_FETCH);
        end
    end

    // Execute stage payload.
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (pop_cmd.kind == KIND_FETCH) begin
                s1_ch_reg     <= 1'b0;
                s1_fetch_reg  <= 1'b1;
                s1_period_reg <= '0;
                s1_done_reg   <= 1'b0;
                s1_sum_reg    <= '0;
                s1_dist_reg   <= '0;
                s1_turn_reg   <= turn_reg[0];
                s1_other_reg  <= turn_reg[1];
            end else begin
                s1_ch_reg     <= ch;
                s1_fetch_reg  <= 1'b0;
                s1_period_reg <= period;
                s1_done_reg   <= done;
                s1_sum_reg    <= sum_sat;
                s1_dist_reg   <= pop_cmd.dist_mode ? dist_inc : dist_reg[ch];
                s1_turn_reg   <= pop_cmd.dist_mode ? turn_reg[ch] : turn_step;
                s1_other_reg  <= '0;
            end
        end
    end

    // Average of a completed group, taken straight into the output register.
    assign prod    = PROD_W'(s1_sum_reg) * PROD_W'(DIV_MUL);
    assign avg_new = prod[DIV_SHIFT +: PERIOD_W];
    assign avg_out = s1_fetch_reg ? '0 : (s1_done_reg ? avg_new : avg_reg[s1_ch_reg]);

    // Latest average per wheel, written in the order words reach the output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg[0] <= '0;
            avg_reg[1] <= '0;
        end else if (s1_adv && s1_done_reg) begin
            avg_reg[s1_ch_reg] <= avg_new;
        end
    end

    // Output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_ch_reg     <= s1_ch_reg;
            m_period_reg <= s1_period_reg;
            m_avg_reg    <= avg_out;
            m_upd_reg    <= s1_done_reg;
            m_dist_reg   <= s1_dist_reg;
            m_turn_reg   <= s1_turn_reg;
            m_other_reg  <= s1_other_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_out_channel      = m_ch_reg;
    assign m_period           = m_period_reg;
    assign m_average_period   = m_avg_reg;
    assign m_average_updated  = m_upd_reg;
    assign m_distance_count   = m_dist_reg;
    assign m_turn_count       = $signed(m_turn_reg);
    assign m_other_turn_count = $signed(m_other_reg);

    `EPT_ASSERT_IMPLY(a_cnt_bound, aclk, aresetn, 1'b1, (cnt_reg[0] < CNT_W'(AVG_COUNT)) && (cnt_reg[1] < CNT_W'(AVG_COUNT)))
    `EPT_ASSERT_NEXT(a_avg_flag, aclk, aresetn, s1_adv && s1_done_reg, m_valid_reg && m_upd_reg)

endmodule

/* design/encoder_period_tachometer_unit.sv */
// Two-wheel encoder tachometer: period capture, averaging over AVG_COUNT periods and edge counting.
// A result word passes the front holding register, the command queue, the execute stage and the output register.
// Throughput: one word per cycle while m_ready does not hold back the output register.
// Reset (synchronous, active low) clears all wheel state and sets the limit to 1000000.
// No clearing pass follows reset; the block accepts words at once.
`timescale 1ns / 1ps

module encoder_period_tachometer_unit import ept_pkg::*; #(
    parameter int AVG_COUNT = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic                       s_channel,
    input  logic [CAP_W-1:0]           s_capture_time,
    input  logic                       s_distance_mode,
    input  logic                       s_forward,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_out_channel,
    output logic [PERIOD_W-1:0]        m_period,
    output logic [PERIOD_W-1:0]        m_average_period,
    output logic                       m_average_updated,
    output logic [CNT32_W-1:0]         m_distance_count,
    output logic signed [CNT32_W-1:0]  m_turn_count,
    output logic signed [CNT32_W-1:0]  m_other_turn_count
);

    logic [LIMIT_W-1:0] limit_reg;
    ept_cmd_t           push_cmd;
    logic               push_valid;
    logic               push_ready;
    ept_cmd_t           pop_cmd;
    logic               pop_valid;
    logic               pop_ready;

    // Configuration register: accumulator ceiling.
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_SAT_LIMIT) ? {{(32 - LIMIT_W){1'b0}}, limit_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[PADDR_W-1] == REG_SAT_LIMIT) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // Decode and hold incoming words.
    ept_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_channel       (s_channel),
        .s_capture_time  (s_capture_time),
        .s_distance_mode (s_distance_mode),
        .s_forward       (s_forward),
        .push_valid      (push_valid),
        .push_cmd        (push_cmd),
        .push_ready      (push_ready)
    );

    // Command queue between the two halves.
    ept_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    // Per-wheel state, averaging and result output.
    ept_back #(
        .AVG_COUNT (AVG_COUNT)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .limit              (limit_reg),
        .pop_valid          (pop_valid),
        .pop_cmd            (pop_cmd),
        .pop_ready          (pop_ready),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_channel      (m_out_channel),
        .m_period           (m_period),
        .m_average_period   (m_average_period),
        .m_average_updated  (m_average_updated),
        .m_distance_count   (m_distance_count),
        .m_turn_count       (m_turn_count),
        .m_other_turn_count (m_other_turn_count)
    );

endmodule

/* sim/tb_encoder_period_tachometer_unit.sv */
`timescale 1ns / 1ps

module tb_encoder_period_tachometer_unit;
    import ept_pkg::*;

    // Op code 3 is not used by the block and must be ignored.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PERIODS_PER_AVERAGE = 6;
    localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(4 * int'(REG_SAT_LIMIT));
    localparam logic [PERIOD_W-1:0] PERIOD_MASK = '1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRILL_ROWS = 13;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int PHASES = 5;

    // One result word as the block presents it.
    typedef struct packed {
        logic                channel;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] avg;
        logic                updated;
        logic [31:0]         distance;
        logic [31:0]         turns;
        logic [31:0]         other_turns;
    } wheel_report_t;

    // One row of the directed table; the expected word is used only when typed is set.
    typedef struct packed {
        logic [1:0]       op;
        logic             ch;
        logic [CAP_W-1:0] cap;
        logic             dm;
        logic             fwd;
        int               reps;
        bit               typed;
        wheel_report_t    want;
    } drill_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_op = OP_TICK;
    logic                      s_channel = 1'b0;
    logic [CAP_W-1:0]          s_capture_time = '0;
    logic                      s_distance_mode = 1'b0;
    logic                      s_forward = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_out_channel;
    logic [PERIOD_W-1:0]       m_period;
    logic [PERIOD_W-1:0]       m_average_period;
    logic                      m_average_updated;
    logic [CNT32_W-1:0]        m_distance_count;
    logic signed [CNT32_W-1:0] m_turn_count;
    logic signed [CNT32_W-1:0] m_other_turn_count;

    // Mirror of the wheel state, kept by the period predictor.
    logic [LIMIT_W-1:0]  limit_model;
    int                  elapsed_ticks [2];
    int unsigned         period_total [2];
    int unsigned         periods_held [2];
    logic [PERIOD_W-1:0] average_held [2];
    logic [31:0]         distance_steps [2];
    logic [31:0]         turn_steps [2];

    wheel_report_t expected_reports [$];
    drill_row_t    drill_rows [DRILL_ROWS];

    int  errors = 0;
    int  results_seen = 0;
    int  averages_seen = 0;
    int  words_sent = 0;
    int  ticks_sent = 0;
    int  fetches_sent = 0;
    int  cycles = 0;
    int  hold_left = 0;
    int  pause_left = 0;
    bit  quiet_tail = 1'b0;

    encoder_period_tachometer_unit #(
        .AVG_COUNT(PERIODS_PER_AVERAGE)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_channel(s_channel),
        .s_capture_time(s_capture_time),
        .s_distance_mode(s_distance_mode),
        .s_forward(s_forward),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_channel(m_out_channel),
        .m_period(m_period),
        .m_average_period(m_average_period),
        .m_average_updated(m_average_updated),
        .m_distance_count(m_distance_count),
        .m_turn_count(m_turn_count),
        .m_other_turn_count(m_other_turn_count)
    );

    // Clock of 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
            $display("tb_encoder_period_tachometer_unit: errors");
            $finish;
        end
    end

    // Works out the result of one accepted word and updates the mirrored wheel state.
    function automatic bit predict_word(input logic [1:0] op, input logic ch,
                                        input logic [CAP_W-1:0] cap, input logic dm,
                                        input logic fwd, output wheel_report_t rep);
        int sum_ticks;
        int unsigned period;
        rep = '0;
        case (op)
            OP_TICK: begin
                for (int w = 0; w < 2; w++) begin
                    elapsed_ticks[w] = elapsed_ticks[w] + TIMER_SPAN;
                    if (elapsed_ticks[w] >= int'(limit_model))
                        elapsed_ticks[w] = int'(limit_model);
                end
                return 1'b0;
            end
            OP_FETCH: begin
                rep.turns = turn_steps[0];
                rep.other_turns = turn_steps[1];
                turn_steps[0] = '0;
                turn_steps[1] = '0;
                return 1'b1;
            end
            OP_CAPTURE: begin
                if (dm)
                    distance_steps[ch] = distance_steps[ch] + 1;
                else if (fwd)
                    turn_steps[ch] = turn_steps[ch] + 1;
                else
                    turn_steps[ch] = turn_steps[ch] - 1;
                // An edge without the expected overflow gives a negative span, read as zero.
                sum_ticks = elapsed_ticks[ch] + int'(cap);
                period = (sum_ticks < 0) ? 0 : (int'(sum_ticks) & int'(PERIOD_MASK));
                elapsed_ticks[ch] = -int'(cap);
                period_total[ch] = period_total[ch] + period;
                if (period_total[ch] > int'(SUM_MAX))
                    period_total[ch] = int'(SUM_MAX);
                periods_held[ch] = periods_held[ch] + 1;
                if (periods_held[ch] >= PERIODS_PER_AVERAGE) begin
                    average_held[ch] = PERIOD_W'(period_total[ch] / PERIODS_PER_AVERAGE);
                    period_total[ch] = 0;
                    periods_held[ch] = 0;
                    rep.updated = 1'b1;
                end
                rep.channel = ch;
                rep.period = PERIOD_W'(period);
                rep.avg = average_held[ch];
                rep.distance = distance_steps[ch];
                rep.turns = turn_steps[ch];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic note_error(input string what);
        errors++;
        $display("%0t: %s", $time, what);
    endtask

    task automatic match_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            note_error($sformatf("%s mismatch, expected %0h, got %0h", what, want, got));
    endtask

    // Result side: checks every accepted word and drives m_ready with short pauses
    // and two long hold-offs that back the block up into its input.
    always @(posedge aclk) begin : result_side
        wheel_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                note_error($sformatf("result word with nothing expected, channel %0d period %0d",
                                     m_out_channel, m_period));
            end else begin
                want = expected_reports.pop_front();
                match_field("out_channel", 32'(want.channel), 32'(m_out_channel));
                match_field("period", 32'(want.period), 32'(m_period));
                match_field("average_period", 32'(want.avg), 32'(m_average_period));
                match_field("average_updated", 32'(want.updated), 32'(m_average_updated));
                match_field("distance_count", want.distance, m_distance_count);
                match_field("turn_count", want.turns, m_turn_count);
                match_field("other_turn_count", want.other_turns, m_other_turn_count);
                if (want.updated)
                    averages_seen++;
            end
            results_seen++;
            if (results_seen == 150 || results_seen == 600)
                hold_left = 80;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (pause_left > 0) begin
            pause_left--;
            m_ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            pause_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Gap before the next word: a random idle gap now and then, none in the tail.
    function automatic int pick_gap();
        if (!quiet_tail && $urandom_range(0, 7) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // Offers one word and waits for it to be taken; the expected result is queued then.
    task automatic offer_word(input logic [1:0] op, input logic ch, input logic [CAP_W-1:0] cap,
                              input logic dm, input logic fwd, input int gap,
                              input bit typed, input wheel_report_t want);
        wheel_report_t rep;
        bit emits;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_channel <= ch;
        s_capture_time <= cap;
        s_distance_mode <= dm;
        s_forward <= fwd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        emits = predict_word(op, ch, cap, dm, fwd, rep);
        if (emits)
            expected_reports.push_back(typed ? want : rep);
        if (op != OP_UNUSED)
            words_sent++;
        if (op == OP_TICK)
            ticks_sent++;
        if (op == OP_FETCH)
            fetches_sent++;
    endtask

    // Lets the block drain; overflow ticks give no result, so the wait goes on past the last expected result.
    task automatic drain_block();
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Writes the saturation limit, then reads it back.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        logic [31:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LIMIT_ADDR;
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        limit_model = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        match_field("saturation_limit readback", 32'(value), readback);
    endtask

    initial begin
        logic [LIMIT_W-1:0] phase_limits [PHASES];
        drill_row_t         row;
        wheel_report_t      none;
        logic [1:0]         op;
        logic [CAP_W-1:0]   cap;
        int                 pick;
        int                 done;

        none = '0;
        limit_model = LIMIT_RESET;
        for (int w = 0; w < 2; w++) begin
            elapsed_ticks[w] = 0;
            period_total[w] = 0;
            periods_held[w] = 0;
            average_held[w] = '0;
            distance_steps[w] = '0;
            turn_steps[w] = '0;
        end

        // Directed words: fields are op, channel, capture time, distance mode, forward,
        // repeats, whether the result is typed in, and the typed result.
        drill_rows[0]  = '{OP_FETCH, 1'b0, 16'd0, 1'b0, 1'b0, 1, 1'b1, '0};
        drill_rows[1]  = '{OP_CAPTURE, 1'b0, 16'd0, 1'b1, 1'b1, 1, 1'b1,
                           '{1'b0, 21'd0, 21'd0, 1'b0, 32'd1, 32'd0, 32'd0}};
        drill_rows[2]  = '{OP_CAPTURE, 1'b1, 16'hFFFF, 1'b0, 1'b1, 1, 1'b1,
                           '{1'b1, 21'd65535, 21'd0, 1'b0, 32'd0, 32'd1, 32'd0}};
        // Edge without an overflow in between: the period is read as zero.
        drill_rows[3]  = '{OP_CAPTURE, 1'b1, 16'd100, 1'b0, 1'b0, 1, 1'b1,
                           '{1'b1, 21'd0, 21'd0, 1'b0, 32'd0, 32'd0, 32'd0}};
        drill_rows[4]  = '{OP_TICK, 1'b0, 16'd0, 1'b0, 1'b0, 1, 1'b0, '0};
        drill_rows[5]  = '{OP_UNUSED, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1, 1'b0, '0};
        drill_rows[6]  = '{OP_CAPTURE, 1'b0, 16'hFFFF, 1'b0, 1'b0, 1, 1'b0, '0};
        drill_rows[7]  = '{OP_FETCH, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1, 1'b0, '0};
        // Enough overflows to pin channel 1 at the limit, a stopped wheel.
        drill_rows[8]  = '{OP_TICK, 1'b1, 16'hFFFF, 1'b1, 1'b1, 16, 1'b0, '0};
        drill_rows[9]  = '{OP_CAPTURE, 1'b1, 16'hFFFF, 1'b1, 1'b0, 1, 1'b0, '0};
        // Completes the first group of six on the right wheel.
        drill_rows[10] = '{OP_CAPTURE, 1'b0, 16'd0, 1'b1, 1'b1, 4, 1'b0, '0};
        drill_rows[11] = '{OP_CAPTURE, 1'b1, 16'd1, 1'b0, 1'b1, 1, 1'b0, '0};
        drill_rows[12] = '{OP_FETCH, 1'b0, 16'd0, 1'b0, 1'b0, 1, 1'b0, '0};

        phase_limits[0] = '1;
        phase_limits[1] = '0;
        phase_limits[2] = 20'd70000;
        phase_limits[3] = LIMIT_W'($urandom_range(1, 1048574));
        phase_limits[4] = LIMIT_RESET;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, run at the reset limit.
        for (int r = 0; r < DRILL_ROWS; r++) begin
            row = drill_rows[r];
            for (int k = 0; k < row.reps; k++)
                offer_word(row.op, row.ch, row.cap, row.dm, row.fwd, pick_gap(),
                           row.typed, row.want);
        end

        // Random part, one phase per limit setting.
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_block();
            write_limit(phase_limits[ph]);
            done = 0;
            while (done < ITEMS_PER_PHASE) begin
                if (ph == PHASES - 1 && done == ITEMS_PER_PHASE - 100)
                    quiet_tail <= 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    op = OP_TICK;
                else if (pick < 85)
                    op = OP_CAPTURE;
                else if (pick < 95)
                    op = OP_FETCH;
                else
                    op = OP_UNUSED;
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    cap = '0;
                else if (pick == 1)
                    cap = '1;
                else
                    cap = CAP_W'($urandom);
                offer_word(op, 1'($urandom), cap, 1'($urandom), 1'($urandom), pick_gap(),
                           1'b0, none);
                if (op != OP_UNUSED)
                    done++;
            end
        end

        // Let the last results arrive, then a short settling time.
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (expected_reports.size() != 0)
            note_error($sformatf("%0d expected results never arrived", expected_reports.size()));

        $display("Sent %0d words (%0d overflow ticks, %0d fetches) over %0d limit settings.",
                 words_sent, ticks_sent, fetches_sent, PHASES + 1);
        $display("Checked %0d result words, %0d of them closing a six-period average.",
                 results_seen, averages_seen);
        if (errors == 0) begin
            $display("tb_encoder_period_tachometer_unit: clean");
        end else begin
            $display("tb_encoder_period_tachometer_unit: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/ept_pkg.sv
design/ept_front.sv
design/ept_queue.sv
design/ept_back.sv
design/encoder_period_tachometer_unit.sv
sim/tb_encoder_period_tachometer_unit.sv
